@@ rtl/core/wis_pkg.sv @@
`timescale 1ns / 1ps

package wis_pkg;

	localparam int MAX_ADS_DEF     = 32;
	localparam int TIME_BITS_DEF   = 16;
	localparam int WEIGHT_BITS_DEF = 16;

	localparam int FIELD_W   = 16;
	localparam int PROFIT_W  = 21;
	localparam int PICK_W    = 5;
	localparam int RES_CAP   = 32;
	localparam int K_W       = 6;
	localparam logic [PROFIT_W-1:0] PROFIT_MAX = 21'h1fffff;

	typedef struct packed {
		logic [FIELD_W-1:0] start_time;
		logic [FIELD_W-1:0] duration;
		logic [FIELD_W-1:0] weight;
		logic               last_item;
	} item_t;

	typedef struct packed {
		logic [PROFIT_W-1:0] total_profit;
		logic [PICK_W-1:0]   pick_index;
		logic                pick_valid;
		logic                overflowed;
		logic                last_result;
	} result_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_CHK,
		S_INS_CMP,
		S_INS_PUT,
		S_DP_INIT,
		S_DP_CHK,
		S_DP_CUR,
		S_SC_CHK,
		S_SC_CMP,
		S_DP_BRD,
		S_DP_UPD,
		S_BT_INIT,
		S_BT_CHK,
		S_BT_EVAL,
		S_BT_END
	} state_t;

	typedef struct packed {
		logic accept;
		logic ins_rd;
		logic ins_shift;
		logic ins_put;
		logic dp_init;
		logic dp_rd;
		logic dp_cur;
		logic sc_rd;
		logic sc_cmp;
		logic best_rd;
		logic dp_upd;
		logic bt_init;
		logic bt_rd;
		logic bt_take;
		logic bt_skip;
		logic bt_end;
	} cmd_t;

	typedef struct packed {
		logic room;
		logic in_last;
		logic last;
		logic j_zero;
		logic end_gt;
		logic i_over;
		logic scan_done;
		logic bt_done;
		logic taken;
		logic pend_v;
		logic out_free;
	} sts_t;

endpackage

@@ rtl/core/wis_ram.sv @@
`timescale 1ns / 1ps

module wis_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/core/wis_ctrl.sv @@
`timescale 1ns / 1ps

module wis_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  wis_pkg::sts_t  sts,
	output wis_pkg::cmd_t  cmd
);

	wis_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wis_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wis_pkg::S_IDLE: begin
				if (item_valid) begin
					if (sts.room) state_d = wis_pkg::S_INS_CHK;
					else if (sts.in_last) state_d = wis_pkg::S_DP_INIT;
				end
			end
			wis_pkg::S_INS_CHK: state_d = sts.j_zero ? wis_pkg::S_INS_PUT : wis_pkg::S_INS_CMP;
			wis_pkg::S_INS_CMP: state_d = sts.end_gt ? wis_pkg::S_INS_CHK : wis_pkg::S_INS_PUT;
			wis_pkg::S_INS_PUT: state_d = sts.last ? wis_pkg::S_DP_INIT : wis_pkg::S_IDLE;
			wis_pkg::S_DP_INIT: state_d = wis_pkg::S_DP_CHK;
			wis_pkg::S_DP_CHK:  state_d = sts.i_over ? wis_pkg::S_BT_INIT : wis_pkg::S_DP_CUR;
			wis_pkg::S_DP_CUR:  state_d = wis_pkg::S_SC_CHK;
			wis_pkg::S_SC_CHK:  state_d = sts.scan_done ? wis_pkg::S_DP_BRD : wis_pkg::S_SC_CMP;
			wis_pkg::S_SC_CMP:  state_d = wis_pkg::S_SC_CHK;
			wis_pkg::S_DP_BRD:  state_d = wis_pkg::S_DP_UPD;
			wis_pkg::S_DP_UPD:  state_d = wis_pkg::S_DP_CHK;
			wis_pkg::S_BT_INIT: state_d = wis_pkg::S_BT_CHK;
			wis_pkg::S_BT_CHK:  state_d = sts.bt_done ? wis_pkg::S_BT_END : wis_pkg::S_BT_EVAL;
			wis_pkg::S_BT_EVAL: begin
				if (!(sts.taken && sts.pend_v && !sts.out_free)) state_d = wis_pkg::S_BT_CHK;
			end
			wis_pkg::S_BT_END: begin
				if (sts.out_free) state_d = wis_pkg::S_IDLE;
			end
			default: state_d = wis_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		item_stall = (state_q != wis_pkg::S_IDLE);
		unique case (state_q)
			wis_pkg::S_IDLE:    cmd.accept = item_valid;
			wis_pkg::S_INS_CHK: cmd.ins_rd = !sts.j_zero;
			wis_pkg::S_INS_CMP: cmd.ins_shift = sts.end_gt;
			wis_pkg::S_INS_PUT: cmd.ins_put = 1'b1;
			wis_pkg::S_DP_INIT: cmd.dp_init = 1'b1;
			wis_pkg::S_DP_CHK:  cmd.dp_rd = !sts.i_over;
			wis_pkg::S_DP_CUR:  cmd.dp_cur = 1'b1;
			wis_pkg::S_SC_CHK:  cmd.sc_rd = !sts.scan_done;
			wis_pkg::S_SC_CMP:  cmd.sc_cmp = 1'b1;
			wis_pkg::S_DP_BRD:  cmd.best_rd = 1'b1;
			wis_pkg::S_DP_UPD:  cmd.dp_upd = 1'b1;
			wis_pkg::S_BT_INIT: cmd.bt_init = 1'b1;
			wis_pkg::S_BT_CHK:  cmd.bt_rd = !sts.bt_done;
			wis_pkg::S_BT_EVAL: begin
				cmd.bt_take = sts.taken && (!sts.pend_v || sts.out_free);
				cmd.bt_skip = !sts.taken;
			end
			wis_pkg::S_BT_END:  cmd.bt_end = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

@@ rtl/core/wis_dp.sv @@
`timescale 1ns / 1ps

module wis_dp #(
	parameter int MAX_ADS     = wis_pkg::MAX_ADS_DEF,
	parameter int TIME_BITS   = wis_pkg::TIME_BITS_DEF,
	parameter int WEIGHT_BITS = wis_pkg::WEIGHT_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  wis_pkg::item_t   item,
	input  logic             result_stall,
	input  wis_pkg::cmd_t    cmd,
	output wis_pkg::sts_t    sts,
	output logic             result_valid,
	output wis_pkg::result_t result
);

	localparam int IDX_W  = (MAX_ADS > 1) ? $clog2(MAX_ADS) : 1;
	localparam int CNT_W  = $clog2(MAX_ADS + 1);
	localparam int END_W  = TIME_BITS + 1;
	localparam int BEST_W = WEIGHT_BITS + CNT_W;
	localparam int REC_W  = TIME_BITS + END_W + WEIGHT_BITS + IDX_W;
	localparam int O_ARR  = 0;
	localparam int O_W    = O_ARR + IDX_W;
	localparam int O_E    = O_W + WEIGHT_BITS;
	localparam int O_S    = O_E + END_W;
	localparam int PRV_W  = CNT_W + 1;
	localparam int K_W_L  = wis_pkg::K_W;

	logic [CNT_W-1:0]       cnt_q, j_q, i_q, p_q;
	logic [K_W_L-1:0]       k_q;
	logic                   ovf_q, last_q, pend_v_q, out_v_q;
	logic [TIME_BITS-1:0]   new_s_q, cur_s_q;
	logic [END_W-1:0]       new_e_q;
	logic [WEIGHT_BITS-1:0] new_w_q, cur_w_q;
	logic [BEST_W-1:0]      best_prev_q;
	logic [IDX_W-1:0]       pend_idx_q;
	wis_pkg::result_t       out_q;

	logic [TIME_BITS-1:0]   in_s, in_d;
	logic [WEIGHT_BITS-1:0] in_w;
	logic [31:0]            s32, d32, w32, pidx32;

	logic                   rec_we, rec_re;
	logic [IDX_W-1:0]       rec_waddr, rec_raddr;
	logic [REC_W-1:0]       rec_wdata, rec_rdata;
	logic [TIME_BITS-1:0]   rd_s;
	logic [END_W-1:0]       rd_e;
	logic [WEIGHT_BITS-1:0] rd_w;
	logic [IDX_W-1:0]       rd_arr;

	logic                   best_we;
	logic [CNT_W-1:0]       best_waddr;
	logic [BEST_W-1:0]      best_wdata, best_rdata, take, new_best;
	logic [PRV_W-1:0]       prv_rdata;
	logic                   taken_now;

	logic [63:0]                  best64;
	logic [wis_pkg::PROFIT_W-1:0] profit_sat;
	logic [wis_pkg::PICK_W-1:0]   pend_pick;

	assign s32  = 32'(item.start_time);
	assign d32  = 32'(item.duration);
	assign w32  = 32'(item.weight);
	assign in_s = s32[TIME_BITS-1:0];
	assign in_d = d32[TIME_BITS-1:0];
	assign in_w = w32[WEIGHT_BITS-1:0];

	assign rd_s   = rec_rdata[O_S +: TIME_BITS];
	assign rd_e   = rec_rdata[O_E +: END_W];
	assign rd_w   = rec_rdata[O_W +: WEIGHT_BITS];
	assign rd_arr = rec_rdata[O_ARR +: IDX_W];

	always_comb begin
		rec_we    = cmd.ins_shift || cmd.ins_put;
		rec_waddr = j_q[IDX_W-1:0];
		rec_wdata = cmd.ins_shift ? rec_rdata : {new_s_q, new_e_q, new_w_q, cnt_q[IDX_W-1:0]};
		rec_re    = cmd.ins_rd || cmd.dp_rd || cmd.sc_rd || cmd.bt_rd;
		priority if (cmd.ins_rd) rec_raddr = j_q[IDX_W-1:0] - IDX_W'(1);
		else if (cmd.dp_rd) rec_raddr = i_q[IDX_W-1:0];
		else if (cmd.sc_rd) rec_raddr = j_q[IDX_W-1:0];
		else rec_raddr = i_q[IDX_W-1:0] - IDX_W'(1);
	end

	wis_ram #(.WIDTH(REC_W), .DEPTH(MAX_ADS)) u_rec (
		.clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
		.re(rec_re), .raddr(rec_raddr), .rdata(rec_rdata)
	);

	assign take      = best_rdata + BEST_W'(cur_w_q);
	assign taken_now = take > best_prev_q;
	assign new_best  = taken_now ? take : best_prev_q;

	always_comb begin
		best_we    = cmd.dp_init || cmd.dp_upd;
		best_waddr = cmd.dp_init ? '0 : i_q + CNT_W'(1);
		best_wdata = cmd.dp_init ? '0 : new_best;
	end

	wis_ram #(.WIDTH(BEST_W), .DEPTH(MAX_ADS + 1)) u_best (
		.clk(clk), .we(best_we), .waddr(best_waddr), .wdata(best_wdata),
		.re(cmd.best_rd), .raddr(p_q), .rdata(best_rdata)
	);

	wis_ram #(.WIDTH(PRV_W), .DEPTH(MAX_ADS + 1)) u_prev (
		.clk(clk), .we(cmd.dp_upd), .waddr(i_q + CNT_W'(1)), .wdata({taken_now, p_q}),
		.re(cmd.bt_rd), .raddr(i_q), .rdata(prv_rdata)
	);

	assign best64     = 64'(best_prev_q);
	assign profit_sat = (best64 > 64'(wis_pkg::PROFIT_MAX)) ? wis_pkg::PROFIT_MAX
	                                                        : best64[wis_pkg::PROFIT_W-1:0];
	assign pidx32     = 32'(pend_idx_q);
	assign pend_pick  = pidx32[wis_pkg::PICK_W-1:0];

	always_comb begin
		sts.room      = cnt_q < CNT_W'(MAX_ADS);
		sts.in_last   = item.last_item;
		sts.last      = last_q;
		sts.j_zero    = (j_q == '0);
		sts.end_gt    = rd_e > new_e_q;
		sts.i_over    = (i_q == cnt_q);
		sts.scan_done = (j_q == i_q);
		sts.bt_done   = (i_q == '0) || (k_q == K_W_L'(wis_pkg::RES_CAP));
		sts.taken     = prv_rdata[PRV_W-1];
		sts.pend_v    = pend_v_q;
		sts.out_free  = !out_v_q || !result_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			ovf_q    <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if ((cmd.bt_take && pend_v_q) || cmd.bt_end) out_v_q <= 1'b1;
			else if (out_v_q && !result_stall) out_v_q <= 1'b0;
			if (cmd.accept && !sts.room) ovf_q <= 1'b1;
			if (cmd.ins_put) cnt_q <= cnt_q + CNT_W'(1);
			if (cmd.bt_init) pend_v_q <= 1'b0;
			if (cmd.bt_take) pend_v_q <= 1'b1;
			if (cmd.bt_end) begin
				pend_v_q <= 1'b0;
				cnt_q    <= '0;
				ovf_q    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			new_s_q <= in_s;
			new_e_q <= END_W'(in_s) + END_W'(in_d);
			new_w_q <= in_w;
			last_q  <= item.last_item;
			j_q     <= cnt_q;
		end
		if (cmd.ins_shift) j_q <= j_q - CNT_W'(1);
		if (cmd.dp_init) begin
			best_prev_q <= '0;
			i_q         <= '0;
		end
		if (cmd.dp_cur) begin
			cur_s_q <= rd_s;
			cur_w_q <= rd_w;
			p_q     <= '0;
			j_q     <= '0;
		end
		if (cmd.sc_cmp) begin
			if (rd_e <= END_W'(cur_s_q)) p_q <= p_q + CNT_W'(1);
			j_q <= j_q + CNT_W'(1);
		end
		if (cmd.dp_upd) begin
			best_prev_q <= new_best;
			i_q         <= i_q + CNT_W'(1);
		end
		if (cmd.bt_init) begin
			i_q <= cnt_q;
			k_q <= '0;
		end
		if (cmd.bt_take) begin
			if (pend_v_q) out_q <= '{profit_sat, pend_pick, 1'b1, ovf_q, 1'b0};
			pend_idx_q <= rd_arr;
			k_q        <= k_q + K_W_L'(1);
			i_q        <= prv_rdata[CNT_W-1:0];
		end
		if (cmd.bt_skip) i_q <= i_q - CNT_W'(1);
		if (cmd.bt_end) begin
			if (pend_v_q) out_q <= '{profit_sat, pend_pick, 1'b1, ovf_q, 1'b1};
			else out_q <= '{profit_sat, '0, 1'b0, ovf_q, 1'b1};
		end
	end

	assign result_valid = out_v_q;
	assign result       = out_q;

endmodule

@@ rtl/core/weighted_interval_scheduler.sv @@
`timescale 1ns / 1ps
// channel   payload    valid         stall
// item      item       item_valid    item_stall
// result    result     result_valid  result_stall
//
// an item not marked last is placed in end-time order: each entry that ends later is shifted up
// one place, then the item is written; no compare is made when it lands in entry zero
// the run after the last item does the end-time scan for every entry,
// then the backtrace; the single read port of the interval memory serializes both
// reset clears the fill count, the overflow flag and all handshake state at once
// a stalled result holds the backtrace until the output register frees

module weighted_interval_scheduler #(
	parameter int MAX_ADS     = wis_pkg::MAX_ADS_DEF,
	parameter int TIME_BITS   = wis_pkg::TIME_BITS_DEF,
	parameter int WEIGHT_BITS = wis_pkg::WEIGHT_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  wis_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output wis_pkg::result_t result
);

	wis_pkg::cmd_t cmd;
	wis_pkg::sts_t sts;

	wis_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .item_valid(item_valid),
		.item_stall(item_stall), .sts(sts), .cmd(cmd)
	);

	wis_dp #(
		.MAX_ADS(MAX_ADS), .TIME_BITS(TIME_BITS), .WEIGHT_BITS(WEIGHT_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .item(item), .result_stall(result_stall),
		.cmd(cmd), .sts(sts), .result_valid(result_valid), .result(result)
	);

endmodule

@@ rtl/core/wis_checker.sv @@
`timescale 1ns / 1ps

module wis_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             result_valid,
	input logic             result_stall,
	input wis_pkg::result_t result
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("stalled result changed");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.pick_valid |-> result.last_result)
		else $error("empty-set result not marked last");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.pick_valid |-> result.total_profit == '0 &&
		result.pick_index == '0)
		else $error("empty-set result carries profit or index");

endmodule

bind weighted_interval_scheduler wis_checker u_wis_checker (
	.clk(clk), .arst_n(arst_n), .result_valid(result_valid),
	.result_stall(result_stall), .result(result)
);
